// ----- rtl/sc2a_pkg.sv -----
// ----------------------------------------------------------------------------
// sc2a_pkg
// Types, scancode constants and lookup tables for the set-1 scancode
// to ASCII translator.
// ----------------------------------------------------------------------------
package sc2a_pkg;

    localparam logic [7:0] SC_BACKSPACE = 8'h0E;
    localparam logic [7:0] SC_ENTER     = 8'h1C;
    localparam logic [7:0] SC_SPACE     = 8'h39;
    localparam logic [7:0] SC_LSHIFT    = 8'h2A;
    localparam logic [7:0] SC_RSHIFT    = 8'h36;
    localparam logic [7:0] SC_LSHIFT_UP = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_UP = 8'hB6;
    localparam logic [7:0] SC_CAPS      = 8'h3A;
    localparam logic [7:0] SC_LCTRL     = 8'h1D;
    localparam logic [7:0] SC_LCTRL_UP  = 8'h9D;
    localparam logic [7:0] SC_KEY_C     = 8'h2E;
    localparam logic [7:0] SC_RELEASE   = 8'h80;

    localparam logic [6:0] ASCII_LOWER_A = 7'h61;
    localparam logic [6:0] ASCII_LOWER_Z = 7'h7A;
    localparam logic [6:0] ASCII_CASE    = 7'h20;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_CHAR       = 3'd1,
        ACT_BACKSPACE  = 3'd2,
        ACT_ENTER      = 3'd3,
        ACT_SPACE      = 3'd4,
        ACT_CANCEL     = 3'd5,
        ACT_CANCEL_RAW = 3'd6,
        ACT_RAW        = 3'd7
    } action_t;

    typedef enum logic {
        KIND_SCANCODE = 1'b0,
        KIND_CLEAR    = 1'b1
    } kind_t;

    typedef struct packed {
        logic cancel;
        logic caps;
        logic ctrl;
        logic shift;
    } flags_t;

    // Packed from the low bit up: key_code, ascii_char, action, flags.
    typedef struct packed {
        logic       cancel_pending;
        logic       caps_on;
        logic       ctrl_down;
        logic       shift_down;
        action_t    action;
        logic [6:0] ascii_char;
        logic [7:0] key_code;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    // Codes 0x3A..0x3F are padding and map to nothing.
    localparam logic [6:0] PLAIN_TAB [0:63] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam logic [6:0] SHIFT_TAB [0:63] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

endpackage

// ----- rtl/sc2a_xlate.sv -----
// ----------------------------------------------------------------------------
// sc2a_xlate
// Combinational translation of one registered item: modifier tracking,
// table lookup, action decode and next keyboard flags.
// ----------------------------------------------------------------------------
module sc2a_xlate
(
    input  logic             passthru,
    input  logic             kind,
    input  logic [7:0]       scancode,
    input  sc2a_pkg::flags_t flags,
    output sc2a_pkg::flags_t flags_next,
    output sc2a_pkg::result_t result
);
    import sc2a_pkg::*;

    logic [6:0] base_char;
    logic [6:0] shift_char;
    logic [6:0] xlat_char;
    logic       is_letter;
    logic       is_modifier;
    logic       in_table;
    logic [6:0] ch;
    action_t    act;

    assign in_table   = (scancode[7:6] == 2'b00);
    assign base_char  = in_table ? PLAIN_TAB[scancode[5:0]] : 7'h00;
    assign shift_char = in_table ? SHIFT_TAB[scancode[5:0]] : 7'h00;
    assign is_letter  = (base_char >= ASCII_LOWER_A) && (base_char <= ASCII_LOWER_Z);

    always_comb
    begin
        flags_next  = flags;
        ch          = 7'h00;
        act         = ACT_NONE;
        is_modifier = 1'b0;
        xlat_char   = 7'h00;

        if (kind == KIND_CLEAR)
        begin
            flags_next.cancel = 1'b0;
        end
        else
        begin
            is_modifier = 1'b1;
            case (scancode)
                SC_LSHIFT, SC_RSHIFT:       flags_next.shift = 1'b1;
                SC_LSHIFT_UP, SC_RSHIFT_UP: flags_next.shift = 1'b0;
                SC_LCTRL:                   flags_next.ctrl  = 1'b1;
                SC_LCTRL_UP:                flags_next.ctrl  = 1'b0;
                default:                    is_modifier      = 1'b0;
            endcase

            if (is_letter)
                xlat_char = (flags.shift ^ flags.caps) ? (base_char ^ ASCII_CASE) : base_char;
            else
                xlat_char = flags.shift ? shift_char : base_char;

            if (scancode == SC_KEY_C && flags_next.ctrl)
            begin
                flags_next.cancel = 1'b1;
                act = passthru ? ACT_CANCEL_RAW : ACT_CANCEL;
            end
            else if (passthru)
            begin
                act = ACT_RAW;
            end
            else if (is_modifier || ((scancode & SC_RELEASE) != 8'h00))
            begin
                act = ACT_NONE;
            end
            else if (scancode == SC_CAPS)
            begin
                flags_next.caps = ~flags.caps;
            end
            else
            begin
                ch = xlat_char;
                if (ch != 7'h00)
                begin
                    case (scancode)
                        SC_BACKSPACE: act = ACT_BACKSPACE;
                        SC_ENTER:     act = ACT_ENTER;
                        SC_SPACE:     act = ACT_SPACE;
                        default:      act = ACT_CHAR;
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        result.key_code       = (kind == KIND_CLEAR) ? 8'h00 : scancode;
        result.ascii_char     = ch;
        result.action         = act;
        result.shift_down     = flags_next.shift;
        result.ctrl_down      = flags_next.ctrl;
        result.caps_on        = flags_next.caps;
        result.cancel_pending = flags_next.cancel;
    end

endmodule

// ----- rtl/scancode_to_ascii_keyboard_unit.sv -----
// ----------------------------------------------------------------------------
// scancode_to_ascii_keyboard_unit
// Set-1 keyboard scancode to ASCII translator with modifier tracking.
// ----------------------------------------------------------------------------
// Each input transfer (a scancode byte, or a clear of the cancel flag when
// tuser is 1) gives exactly one output transfer. The block takes one transfer
// per cycle unless the output stalls: an input register feeds a single table
// lookup and flag update, which loads the output register. Shift, left ctrl,
// caps lock and the sticky ctrl+C flag advance as each item leaves the input
// register. The passthru register (1 passes scancodes untranslated) may be
// written only while no transfer is in flight.
module scancode_to_ascii_keyboard_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        passthru_we,
    input  logic        passthru_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] scancode
    input  logic [0:0]  s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [7:0] key_code, [14:8] ascii_char,
                                        // [17:15] action, [18] shift_down,
                                        // [19] ctrl_down, [20] caps_on,
                                        // [21] cancel_pending, [23:22] zero
);
    import sc2a_pkg::*;

    logic    passthru_reg;
    logic    in_valid_reg;
    logic    in_kind_reg;
    logic [7:0] in_code_reg;
    logic    out_valid_reg;
    result_t out_reg;
    flags_t  flags_reg;

    flags_t  flags_next;
    result_t result_next;
    logic    advance;
    logic    in_xfer;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(TDATA_W - RESULT_W)'(0), out_reg};

    sc2a_xlate u_xlate
    (
        .passthru   (passthru_reg),
        .kind       (in_kind_reg),
        .scancode   (in_code_reg),
        .flags      (flags_reg),
        .flags_next (flags_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            passthru_reg  <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (passthru_we)
                passthru_reg <= passthru_wdata;

            if (in_xfer)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_kind_reg <= s_axis_tuser[0];
            in_code_reg <= s_axis_tdata;
        end
        if (advance)
            out_reg <= result_next;
    end

    a_cancel_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.action == ACT_CANCEL || out_reg.action == ACT_CANCEL_RAW)
        |-> out_reg.cancel_pending && out_reg.ctrl_down && out_reg.key_code == SC_KEY_C)
        else $error("cancel action without ctrl+C state");

    a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.action == ACT_CHAR || out_reg.action == ACT_BACKSPACE ||
                          out_reg.action == ACT_ENTER || out_reg.action == ACT_SPACE)
        |-> out_reg.ascii_char != 7'h00)
        else $error("character action with empty character");

    a_raw_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.action == ACT_RAW || out_reg.action == ACT_CANCEL_RAW)
        |-> passthru_reg && out_reg.ascii_char == 7'h00)
        else $error("raw action outside raw mode or with a character");

    a_cancel_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(flags_reg.cancel) |-> out_valid_reg &&
            (out_reg.action == ACT_CANCEL || out_reg.action == ACT_CANCEL_RAW))
        else $error("cancel flag set without a cancel transfer");

    a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
        $past(advance) |-> out_reg.cancel_pending == flags_reg.cancel &&
            out_reg.caps_on == flags_reg.caps && out_reg.shift_down == flags_reg.shift)
        else $error("reported flags differ from flag state");

endmodule
